>>> rtl/core/tnrcp_pkg.sv
`timescale 1ns / 1ps

package tnrcp_pkg;

   localparam logic [7:0] IAC         = 8'd255;
   localparam logic [7:0] CMD_MIN     = 8'd240;
   localparam logic [7:0] CMD_WILL    = 8'd251;
   localparam logic [7:0] CMD_WONT    = 8'd252;
   localparam logic [7:0] CMD_DO      = 8'd253;
   localparam logic [7:0] CMD_DONT    = 8'd254;
   localparam logic [7:0] ECHO_OPTION = 8'd1;
   localparam logic [7:0] SGA_OPTION  = 8'd3;

   // held byte counts of the parser
   localparam logic [1:0] HELD_NONE = 2'd0;
   localparam logic [1:0] HELD_IAC  = 2'd1;
   localparam logic [1:0] HELD_CMD  = 2'd2;

   // classified byte handed from the parser to the negotiation side
   typedef struct packed {
      logic [1:0] show_count;
      logic [7:0] show_first;
      logic [7:0] show_second;
      logic       opt_valid;
      logic [7:0] opt_command;
      logic [7:0] opt_code;
   } op_type;

   // one finished result
   typedef struct packed {
      logic [1:0] show_count;
      logic [7:0] show_first;
      logic [7:0] show_second;
      logic       reply_valid;
      logic [7:0] reply_command;
      logic [7:0] reply_option;
      logic       local_echo;
   } rsp_type;

endpackage

>>> rtl/core/tnrcp_front.sv
`timescale 1ns / 1ps

module tnrcp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [7:0]         rx_byte,
   input  logic               queue_full,
   output logic               op_push,
   output tnrcp_pkg::op_type  op
);
   import tnrcp_pkg::*;

   logic       in_command_ff, in_command_in;
   logic [1:0] held_count_ff, held_count_in;
   logic [7:0] held_command_ff, held_command_in;
   logic       accept;

   assign accept  = push && !queue_full;
   assign op_push = accept;

   always_comb begin
      in_command_in   = in_command_ff;
      held_count_in   = held_count_ff;
      held_command_in = held_command_ff;
      op              = '0;
      if (!in_command_ff) begin
         if (rx_byte == IAC) begin
            in_command_in = 1'b1;
            held_count_in = HELD_IAC;
         end else if (rx_byte != 8'd0) begin
            op.show_count = 2'd1;
            op.show_first = rx_byte;
         end
      end else if (held_count_ff < HELD_CMD) begin
         // awaiting the command code
         priority if (rx_byte < CMD_MIN) begin
            op.show_count  = 2'd2;
            op.show_first  = IAC;
            op.show_second = rx_byte;
            in_command_in  = 1'b0;
            held_count_in  = HELD_NONE;
         end else if (rx_byte == IAC) begin
            op.show_count = 2'd1;
            op.show_first = IAC;
            in_command_in = 1'b0;
            held_count_in = HELD_NONE;
         end else if (rx_byte < CMD_WILL) begin
            in_command_in = 1'b0;
            held_count_in = HELD_NONE;
         end else begin
            held_command_in = rx_byte;
            held_count_in   = HELD_CMD;
         end
      end else begin
         // option byte of a negotiation command
         op.opt_valid   = 1'b1;
         op.opt_command = held_command_ff;
         op.opt_code    = rx_byte;
         in_command_in  = 1'b0;
         held_count_in  = HELD_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_command_ff   <= 1'b0;
         held_count_ff   <= HELD_NONE;
         held_command_ff <= 8'd0;
      end else if (accept) begin
         in_command_ff   <= in_command_in;
         held_count_ff   <= held_count_in;
         held_command_ff <= held_command_in;
      end
   end

`ifndef ASSERT_OFF
   a_mode_matches_count: assert property (@(posedge clock) disable iff (reset)
      in_command_ff == (held_count_ff != HELD_NONE))
      else $error("parser mode and held count disagree");
   a_held_cmd_is_nego: assert property (@(posedge clock) disable iff (reset)
      (held_count_ff == HELD_CMD) |-> (held_command_ff >= CMD_WILL))
      else $error("held command is not a negotiation command");
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !op_push)
      else $error("parser pushed into a full queue");
`endif

endmodule

>>> rtl/core/tnrcp_queue.sv
`timescale 1ns / 1ps

module tnrcp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tnrcp_pkg::op_type  push_op,
   output logic               full,
   output logic               empty,
   input  logic               pop,
   output tnrcp_pkg::op_type  head
);
   import tnrcp_pkg::*;

   op_type     slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("queue count out of range");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("queue popped while empty");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

>>> rtl/core/tnrcp_back.sv
`timescale 1ns / 1ps

module tnrcp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               op_ready,
   input  tnrcp_pkg::op_type  op,
   output logic               op_pop,
   output logic               empty,
   input  logic               pop,
   output tnrcp_pkg::rsp_type head
);
   import tnrcp_pkg::*;

   logic       echo_flag_ff, echo_flag_in;
   logic       acked_echo_ff, acked_echo_in;
   logic       acked_sga_ff, acked_sga_in;
   rsp_type    res;
   rsp_type    slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       out_full, take, deq;

   assign out_full = (count_ff == 2'd2);
   assign take     = op_ready && !out_full;
   assign op_pop   = take;
   assign empty    = (count_ff == 2'd0);
   assign deq      = pop && !empty;
   assign head     = slot_ff[rd_ptr_ff];

   always_comb begin
      echo_flag_in      = echo_flag_ff;
      acked_echo_in     = acked_echo_ff;
      acked_sga_in      = acked_sga_ff;
      res               = '0;
      res.show_count    = op.show_count;
      res.show_first    = op.show_first;
      res.show_second   = op.show_second;
      if (op.opt_valid) begin
         if (op.opt_command == CMD_WILL) begin
            if (op.opt_code == ECHO_OPTION) begin
               echo_flag_in = 1'b0;
               if (!acked_echo_ff) begin
                  acked_echo_in     = 1'b1;
                  res.reply_valid   = 1'b1;
                  res.reply_command = CMD_DO;
                  res.reply_option  = op.opt_code;
               end
            end else if (op.opt_code == SGA_OPTION) begin
               if (!acked_sga_ff) begin
                  acked_sga_in      = 1'b1;
                  res.reply_valid   = 1'b1;
                  res.reply_command = CMD_DO;
                  res.reply_option  = op.opt_code;
               end
            end else begin
               res.reply_valid   = 1'b1;
               res.reply_command = CMD_DONT;
               res.reply_option  = op.opt_code;
            end
         end else if (op.opt_command == CMD_DO) begin
            res.reply_valid   = 1'b1;
            res.reply_command = CMD_WONT;
            res.reply_option  = op.opt_code;
         end
      end
      res.local_echo = echo_flag_in;
   end

   always_ff @(posedge clock) begin
      if (take) begin
         slot_ff[wr_ptr_ff] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         echo_flag_ff  <= 1'b1;
         acked_echo_ff <= 1'b0;
         acked_sga_ff  <= 1'b0;
         wr_ptr_ff     <= 1'b0;
         rd_ptr_ff     <= 1'b0;
         count_ff      <= 2'd0;
      end else begin
         if (take) begin
            echo_flag_ff  <= echo_flag_in;
            acked_echo_ff <= acked_echo_in;
            acked_sga_ff  <= acked_sga_in;
            wr_ptr_ff     <= !wr_ptr_ff;
         end
         if (deq) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         unique case ({take, deq})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_echo_never_back: assert property (@(posedge clock) disable iff (reset)
      !echo_flag_ff |=> !echo_flag_ff)
      else $error("local echo came back on without reset");
   a_ack_sticky: assert property (@(posedge clock) disable iff (reset)
      (acked_echo_ff |=> acked_echo_ff) and (acked_sga_ff |=> acked_sga_ff))
      else $error("option acknowledge cleared without reset");
   a_echo_ack_order: assert property (@(posedge clock) disable iff (reset)
      acked_echo_ff |-> !echo_flag_ff)
      else $error("echo acknowledged while local echo still on");
   a_out_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("result buffer count out of range");
`endif

endmodule

>>> rtl/core/telnet_receive_command_parser.sv
`timescale 1ns / 1ps

// telnet receive command parser
// input queue side: drive req_rx_byte and raise req_push; the byte is taken
// at a rising edge where req_push is high and req_full is low
// result queue side: while rsp_empty is low the oldest result sits on the
// rsp_ ports; raise rsp_pop to take it at the next rising edge
// each input byte gives exactly one result: bytes to display, an optional
// three byte negotiation reply (0xff, command, option) and the echo flag
// a byte goes into the middle queue, then into the result buffer, then out
// throughput: one byte per cycle sustained while the receiver keeps popping;
// the parser and the negotiation side each do one byte per cycle unless held
// by a full queue behind them, joined by a two entry queue, with a two entry
// result buffer at the output
// when the receiver stops popping, the result buffer and then the middle
// queue fill and req_full rises; nothing is dropped
// synchronous reset: text mode, no bytes held, no option acknowledged,
// local echo on, both queues empty
module telnet_receive_command_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_rx_byte,
   output logic       req_full,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_show_count,
   output logic [7:0] rsp_show_first,
   output logic [7:0] rsp_show_second,
   output logic       rsp_reply_valid,
   output logic [7:0] rsp_reply_command,
   output logic [7:0] rsp_reply_option,
   output logic       rsp_local_echo
);
   import tnrcp_pkg::*;

   // parser to queue
   logic    front_push;
   op_type  front_op;
   // queue to negotiation side
   logic    mid_full, mid_empty, mid_pop;
   op_type  mid_head;
   rsp_type rsp_head;

   assign req_full = mid_full;

   // front: iac / command / option byte tracking
   tnrcp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .rx_byte    (req_rx_byte),
      .queue_full (mid_full),
      .op_push    (front_push),
      .op         (front_op)
   );

   // decoupling queue
   tnrcp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (front_push),
      .push_op (front_op),
      .full    (mid_full),
      .empty   (mid_empty),
      .pop     (mid_pop),
      .head    (mid_head)
   );

   // back: option negotiation, echo flag and result buffer
   tnrcp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op_ready (!mid_empty),
      .op       (mid_head),
      .op_pop   (mid_pop),
      .empty    (rsp_empty),
      .pop      (rsp_pop),
      .head     (rsp_head)
   );

   assign rsp_show_count    = rsp_head.show_count;
   assign rsp_show_first    = rsp_head.show_first;
   assign rsp_show_second   = rsp_head.show_second;
   assign rsp_reply_valid   = rsp_head.reply_valid;
   assign rsp_reply_command = rsp_head.reply_command;
   assign rsp_reply_option  = rsp_head.reply_option;
   assign rsp_local_echo    = rsp_head.local_echo;

`ifndef ASSERT_OFF
   a_full_only_with_backlog: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !rsp_empty)
      else $error("input stalled while no result is waiting");
   a_reply_has_command: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_reply_valid) |-> (rsp_reply_command == CMD_DO
         || rsp_reply_command == CMD_DONT || rsp_reply_command == CMD_WONT))
      else $error("reply with an unexpected command");
   a_show_bound: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_show_count != 2'd3))
      else $error("display count out of range");
`endif

endmodule
